// ===== hdl/xtnc_pkg.sv =====
`default_nettype none

package xtnc_pkg;

    // Sizing
    localparam int MAX_TAG_BYTES = 16;
    localparam int STACK_DEPTH   = 32;

    // tag_position runs 0 .. MAX_TAG_BYTES+1, a stored length 0 .. MAX_TAG_BYTES
    localparam int POS_W = $clog2(MAX_TAG_BYTES + 2);
    localparam int LEN_W = $clog2(MAX_TAG_BYTES + 1);
    localparam int BYTE_IDX_W = (MAX_TAG_BYTES > 1) ? $clog2(MAX_TAG_BYTES) : 1;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int ENTRY_IDX_W = $clog2(STACK_DEPTH);

    // Characters of interest
    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    // Parser modes
    localparam logic [1:0] MODE_OUT   = 2'd0;
    localparam logic [1:0] MODE_FIRST = 2'd1;
    localparam logic [1:0] MODE_OPEN  = 2'd2;
    localparam logic [1:0] MODE_CLOSE = 2'd3;

    // Verdict codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_UNCLOSED   = 3'd1;
    localparam logic [2:0] ERR_CLOSE_EMPTY = 3'd2;
    localparam logic [2:0] ERR_MISMATCH   = 3'd3;
    localparam logic [2:0] ERR_UNTERM     = 3'd4;
    localparam logic [2:0] ERR_TOO_LONG   = 3'd5;
    localparam logic [2:0] ERR_STACK_FULL = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic       doc_valid;
        logic [2:0] error_code;
    } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/xml_tag_nesting_checker_core.sv =====
`default_nettype none
// Tag nesting checker: one document byte per input item, one verdict per document.
//
// Input channel (in_valid/in_ready/in_data): data_byte plus last_byte, which
// marks the final byte of a document. Output channel (out_valid/out_ready/
// out_data): one verdict item (doc_valid, error_code) per document, produced
// for the item that carries last_byte.
//
// Throughput is one byte per cycle, except that a last byte waits while the
// output register is full. An accepted byte lands in the input register and
// is parsed from there; its verdict (if any) is loaded into the output
// register, which drives out_valid. The closing-tag compare reads the top
// stack entry byte by byte from the text memory; its address is prefetched
// from the next parser state so the byte is ready when the item is parsed.
//
// Reset clears the parser state, stack count and both handshake registers; the
// stack memories need no clearing. After each verdict the parser returns to
// its reset state. When the receiver stalls, bytes without last_byte keep
// flowing; a last byte waits in the input register until the output register
// is free, and in_ready drops behind it.
module xml_tag_nesting_checker_core (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire xtnc_pkg::in_item_t in_data,
    output logic                    out_valid,
    input  wire                     out_ready,
    output xtnc_pkg::out_item_t     out_data
);

    // Stack storage
    logic [7:0] text_mem [xtnc_pkg::STACK_DEPTH][xtnc_pkg::MAX_TAG_BYTES];
    logic [xtnc_pkg::LEN_W-1:0] len_mem [xtnc_pkg::STACK_DEPTH];
    logic [7:0] text_rd_reg;
    logic [xtnc_pkg::LEN_W-1:0] len_rd_reg;

    // Handshake registers
    logic                   in_valid_reg;
    xtnc_pkg::in_item_t     in_item_reg;
    logic                   out_valid_reg;
    xtnc_pkg::out_item_t    out_item_reg;

    // Parser state
    logic [1:0]                 mode_reg, mode_next;
    logic [xtnc_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [xtnc_pkg::CNT_W-1:0] count_reg, count_next;
    logic [2:0]                 err_reg, err_next;
    logic                       mism_reg, mism_next;

    logic                       advance;
    logic                       out_free;
    logic                       out_load;
    xtnc_pkg::out_item_t        out_item_next;

    logic                           txt_we;
    logic [xtnc_pkg::ENTRY_IDX_W-1:0] txt_wr_entry;
    logic [xtnc_pkg::BYTE_IDX_W-1:0]  txt_wr_byte;
    logic                           len_we;
    logic [xtnc_pkg::ENTRY_IDX_W-1:0] len_wr_entry;
    logic [xtnc_pkg::LEN_W-1:0]     len_wr_data;
    logic [xtnc_pkg::CNT_W-1:0]     top_next;
    logic [xtnc_pkg::ENTRY_IDX_W-1:0] rd_entry;
    logic [xtnc_pkg::BYTE_IDX_W-1:0]  rd_byte;

    // Handshake control
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && (!in_item_reg.last_byte || out_free);
    assign in_ready = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // Parse one byte and form the verdict
    always_comb
    begin
        logic [7:0]                 b;
        logic [xtnc_pkg::POS_W-1:0] eff_pos;
        logic [xtnc_pkg::POS_W-1:0] top_len;
        logic [2:0]                 code;

        b       = in_item_reg.data_byte;
        eff_pos = (mode_reg == xtnc_pkg::MODE_FIRST) ? '0 : pos_reg;
        top_len = xtnc_pkg::POS_W'(len_rd_reg);
        code    = xtnc_pkg::ERR_NONE;

        mode_next     = mode_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        err_next      = err_reg;
        mism_next     = mism_reg;
        txt_we        = 1'b0;
        len_we        = 1'b0;
        txt_wr_entry  = count_reg[xtnc_pkg::ENTRY_IDX_W-1:0];
        txt_wr_byte   = eff_pos[xtnc_pkg::BYTE_IDX_W-1:0];
        len_wr_entry  = count_reg[xtnc_pkg::ENTRY_IDX_W-1:0];
        len_wr_data   = eff_pos[xtnc_pkg::LEN_W-1:0];
        out_load      = 1'b0;
        out_item_next = '0;

        if (advance)
        begin
            if (err_reg == xtnc_pkg::ERR_NONE)
            begin
                if (mode_reg == xtnc_pkg::MODE_FIRST)
                begin
                    pos_next  = '0;
                    mism_next = 1'b0;
                end
                unique case (mode_reg) inside
                    xtnc_pkg::MODE_OUT:
                    begin
                        if (b == xtnc_pkg::CHAR_LT)
                            mode_next = xtnc_pkg::MODE_FIRST;
                    end
                    xtnc_pkg::MODE_FIRST, xtnc_pkg::MODE_OPEN:
                    begin
                        if (b == xtnc_pkg::CHAR_GT)
                        begin
                            // end of opening tag: push
                            mode_next = xtnc_pkg::MODE_OUT;
                            if (count_reg >= xtnc_pkg::CNT_W'(xtnc_pkg::STACK_DEPTH))
                                err_next = xtnc_pkg::ERR_STACK_FULL;
                            else
                            begin
                                len_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        else if (mode_reg == xtnc_pkg::MODE_FIRST && b == xtnc_pkg::CHAR_SLASH)
                            mode_next = xtnc_pkg::MODE_CLOSE;
                        else
                        begin
                            // opening tag text byte
                            mode_next = xtnc_pkg::MODE_OPEN;
                            if (eff_pos >= xtnc_pkg::POS_W'(xtnc_pkg::MAX_TAG_BYTES))
                                err_next = xtnc_pkg::ERR_TOO_LONG;
                            else
                            begin
                                txt_we   = (count_reg < xtnc_pkg::CNT_W'(xtnc_pkg::STACK_DEPTH));
                                pos_next = eff_pos + 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        if (b == xtnc_pkg::CHAR_GT)
                        begin
                            // end of closing tag: check and pop
                            mode_next = xtnc_pkg::MODE_OUT;
                            if (count_reg == '0)
                                err_next = xtnc_pkg::ERR_CLOSE_EMPTY;
                            else if (mism_reg || pos_reg != top_len)
                                err_next = xtnc_pkg::ERR_MISMATCH;
                            else
                                count_next = count_reg - 1'b1;
                        end
                        else
                        begin
                            // closing tag text byte against top entry
                            if (count_reg != '0)
                            begin
                                if (pos_reg >= top_len
                                    || pos_reg >= xtnc_pkg::POS_W'(xtnc_pkg::MAX_TAG_BYTES))
                                    mism_next = 1'b1;
                                else if (text_rd_reg != b)
                                    mism_next = 1'b1;
                            end
                            if (pos_reg <= xtnc_pkg::POS_W'(xtnc_pkg::MAX_TAG_BYTES))
                                pos_next = pos_reg + 1'b1;
                        end
                    end
                endcase
            end

            if (in_item_reg.last_byte)
            begin
                if (err_next != xtnc_pkg::ERR_NONE)
                    code = err_next;
                else if (mode_next != xtnc_pkg::MODE_OUT)
                    code = xtnc_pkg::ERR_UNTERM;
                else if (count_next != '0)
                    code = xtnc_pkg::ERR_UNCLOSED;
                else
                    code = xtnc_pkg::ERR_NONE;
                out_load                 = 1'b1;
                out_item_next.doc_valid  = (code == xtnc_pkg::ERR_NONE);
                out_item_next.error_code = code;
                // back to reset state for the next document
                mode_next  = xtnc_pkg::MODE_OUT;
                pos_next   = '0;
                count_next = '0;
                err_next   = xtnc_pkg::ERR_NONE;
                mism_next  = 1'b0;
            end
        end
    end

    // Prefetch address: top entry and byte position of the next state
    assign top_next = count_next - 1'b1;
    assign rd_entry = top_next[xtnc_pkg::ENTRY_IDX_W-1:0];
    assign rd_byte  = pos_next[xtnc_pkg::BYTE_IDX_W-1:0];

    // Stack memories
    always_ff @(posedge clk)
    begin
        if (txt_we)
            text_mem[txt_wr_entry][txt_wr_byte] <= in_item_reg.data_byte;
        text_rd_reg <= text_mem[rd_entry][rd_byte];
        if (len_we)
            len_mem[len_wr_entry] <= len_wr_data;
        // a push makes the new entry the top: forward its length
        if (len_we && len_wr_entry == rd_entry)
            len_rd_reg <= len_wr_data;
        else
            len_rd_reg <= len_mem[rd_entry];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_item_reg <= in_data;
        if (out_load)
            out_item_reg <= out_item_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= xtnc_pkg::MODE_OUT;
            pos_reg       <= '0;
            count_reg     <= '0;
            err_reg       <= xtnc_pkg::ERR_NONE;
            mism_reg      <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            err_reg   <= err_next;
            mism_reg  <= mism_next;
        end
    end

endmodule

`default_nettype wire
